[src/rhsv_pkg.sv]
// types, widths and constants shared by the rgb to hsv converter
package rhsv_pkg;

    localparam int CHANNEL_BITS      = 8;
    localparam int HUE_FRACTION_BITS = 6;

    localparam int HUE_BITS      = HUE_FRACTION_BITS + 9;
    localparam int SAT_NUM_BITS  = 2 * CHANNEL_BITS;
    localparam int HUE_QUO_BITS  = HUE_FRACTION_BITS + 6;
    localparam int HUE_NUM_BITS  = CHANNEL_BITS + HUE_QUO_BITS;
    localparam int DIV_STAGES    = (CHANNEL_BITS > HUE_QUO_BITS) ? CHANNEL_BITS : HUE_QUO_BITS;

    localparam logic [HUE_BITS-1:0] HUE_120  = HUE_BITS'(120 * (1 << HUE_FRACTION_BITS));
    localparam logic [HUE_BITS-1:0] HUE_240  = HUE_BITS'(240 * (1 << HUE_FRACTION_BITS));
    localparam logic [HUE_BITS-1:0] HUE_FULL = HUE_BITS'(360 * (1 << HUE_FRACTION_BITS));

    typedef enum logic [1:0] {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } sector_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [HUE_BITS-1:0]     hue;
        logic [CHANNEL_BITS-1:0] saturation;
        logic [CHANNEL_BITS-1:0] brightness;
    } hsv_t;

    // per-item control that rides alongside the divider stages
    typedef struct packed {
        logic [CHANNEL_BITS-1:0] hi;
        logic                    grey;
        sector_t                 sector;
        logic                    neg;
    } side_t;

endpackage

[src/rgb_to_hsv_converter.sv]
// rgb to hsv converter: pipelined max/min, numerators, two restoring dividers, hue fixup
//
// One pixel is taken in every clock cycle (start high; busy is always low) and its
// hsv result appears with done at the end of the pipeline. Most stages of the pipeline
// are the two restoring dividers, which settle one quotient bit per stage: saturation
// needs CHANNEL_BITS bits and hue needs HUE_FRACTION_BITS + 6 bits, and both run
// side by side for the longer of the two. Results are shown for a single cycle and
// must be taken then. Hue is in units of 1/2^HUE_FRACTION_BITS degree; grey pixels
// give hue and saturation 0.
module rgb_to_hsv_converter (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  rhsv_pkg::pixel_t pixel,
    output logic            done,
    output rhsv_pkg::hsv_t   hsv
);
    import rhsv_pkg::*;

    localparam int CB      = CHANNEL_BITS;
    localparam int HQ      = HUE_QUO_BITS;
    localparam int LATENCY = DIV_STAGES + 3;

    // stage 1: max, min, sector and channel difference
    logic                 s1_valid_reg;
    logic [CB-1:0]        s1_hi_reg;
    logic [CB-1:0]        s1_delta_reg;
    sector_t              s1_sector_reg;
    logic                 s1_neg_reg;
    logic [CB-1:0]        s1_mag_reg;

    logic [CB-1:0]        rg_hi;
    logic [CB-1:0]        rg_lo;
    logic [CB-1:0]        s1_hi_next;
    logic [CB-1:0]        s1_lo;
    sector_t              s1_sector_next;
    logic [CB-1:0]        op_a;
    logic [CB-1:0]        op_c;
    logic                 s1_neg_next;
    logic [CB-1:0]        s1_mag_next;

    // divider pipeline, index 0 is the numerator stage
    logic                    dv_valid_reg [0:DIV_STAGES];
    side_t                   dv_side_reg  [0:DIV_STAGES];
    logic [SAT_NUM_BITS-1:0] dv_srem_reg  [0:DIV_STAGES];
    logic [CB-1:0]           dv_sq_reg    [0:DIV_STAGES];
    logic [HUE_NUM_BITS-1:0] dv_hrem_reg  [0:DIV_STAGES];
    logic [HQ-1:0]           dv_hq_reg    [0:DIV_STAGES];
    // divisor of the hue divider
    logic [CB-1:0]           dv_delta_reg [0:DIV_STAGES];

    logic [CB+5:0]           mag60;
    side_t                   side0_next;

    // output stage
    logic                 done_reg;
    hsv_t                 hsv_reg;
    hsv_t                 hsv_next;
    side_t                fin_side;
    logic [HUE_BITS-1:0]  hq_ext;
    logic [HUE_BITS-1:0]  hue_base;
    logic                 rem_nz;

    // the pipeline never stalls, so an item is taken whenever start is high
    assign busy = 1'b0;

    always_comb
    begin
        rg_hi      = (pixel.red > pixel.green) ? pixel.red : pixel.green;
        rg_lo      = (pixel.red < pixel.green) ? pixel.red : pixel.green;
        s1_hi_next = (pixel.blue > rg_hi) ? pixel.blue : rg_hi;
        s1_lo      = (pixel.blue < rg_lo) ? pixel.blue : rg_lo;
        // ties go to red, then green
        if (pixel.red == s1_hi_next)
        begin
            s1_sector_next = SECTOR_RED;
            op_a           = pixel.green;
            op_c           = pixel.blue;
        end
        else if (pixel.green == s1_hi_next)
        begin
            s1_sector_next = SECTOR_GREEN;
            op_a           = pixel.blue;
            op_c           = pixel.red;
        end
        else
        begin
            s1_sector_next = SECTOR_BLUE;
            op_a           = pixel.red;
            op_c           = pixel.green;
        end
        s1_neg_next = op_a < op_c;
        s1_mag_next = s1_neg_next ? (op_c - op_a) : (op_a - op_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_hi_reg     <= s1_hi_next;
        s1_delta_reg  <= s1_hi_next - s1_lo;
        s1_sector_reg <= s1_sector_next;
        s1_neg_reg    <= s1_neg_next;
        s1_mag_reg    <= s1_mag_next;
    end

    // stage 2: numerators, |diff| * 60 by shift and subtract
    always_comb
    begin
        mag60             = {s1_mag_reg, 6'b0} - {4'b0, s1_mag_reg, 2'b0};
        side0_next.hi     = s1_hi_reg;
        side0_next.grey   = (s1_delta_reg == '0);
        side0_next.sector = s1_sector_reg;
        side0_next.neg    = s1_neg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else
        begin
            dv_valid_reg[0] <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dv_side_reg[0]  <= side0_next;
        dv_srem_reg[0]  <= {s1_delta_reg, CB'(0)} - SAT_NUM_BITS'(s1_delta_reg);
        dv_sq_reg[0]    <= '0;
        dv_hrem_reg[0]  <= HUE_NUM_BITS'(mag60) << HUE_FRACTION_BITS;
        dv_hq_reg[0]    <= '0;
        dv_delta_reg[0] <= s1_delta_reg;
    end

    // each divider settles one quotient bit per stage, msb first, until its quotient is full
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        logic [SAT_NUM_BITS-1:0] srem_next;
        logic [CB-1:0]           sq_next;
        logic [HUE_NUM_BITS-1:0] hrem_next;
        logic [HQ-1:0]           hq_next;

        if (k < CB)
        begin : g_sat
            logic [SAT_NUM_BITS-1:0] s_div;
            always_comb
            begin
                s_div     = SAT_NUM_BITS'(dv_side_reg[k].hi) << (CB - 1 - k);
                srem_next = dv_srem_reg[k];
                sq_next   = dv_sq_reg[k];
                if (dv_srem_reg[k] >= s_div)
                begin
                    srem_next           = dv_srem_reg[k] - s_div;
                    sq_next[CB - 1 - k] = 1'b1;
                end
            end
        end
        else
        begin : g_sat_pass
            always_comb
            begin
                srem_next = dv_srem_reg[k];
                sq_next   = dv_sq_reg[k];
            end
        end

        if (k < HQ)
        begin : g_hue
            logic [HUE_NUM_BITS-1:0] h_div;
            always_comb
            begin
                h_div     = HUE_NUM_BITS'(dv_delta_reg[k]) << (HQ - 1 - k);
                hrem_next = dv_hrem_reg[k];
                hq_next   = dv_hq_reg[k];
                if (dv_hrem_reg[k] >= h_div)
                begin
                    hrem_next           = dv_hrem_reg[k] - h_div;
                    hq_next[HQ - 1 - k] = 1'b1;
                end
            end
        end
        else
        begin : g_hue_pass
            always_comb
            begin
                hrem_next = dv_hrem_reg[k];
                hq_next   = dv_hq_reg[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_side_reg[k+1]  <= dv_side_reg[k];
            dv_srem_reg[k+1]  <= srem_next;
            dv_sq_reg[k+1]    <= sq_next;
            dv_hrem_reg[k+1]  <= hrem_next;
            dv_hq_reg[k+1]    <= hq_next;
            dv_delta_reg[k+1] <= dv_delta_reg[k];
        end
    end

    // final stage: sector offset and sign fixup of the hue quotient, zero hue and saturation for grey
    always_comb
    begin
        fin_side = dv_side_reg[DIV_STAGES];
        hq_ext   = HUE_BITS'(dv_hq_reg[DIV_STAGES]);
        rem_nz   = (dv_hrem_reg[DIV_STAGES] != '0);
        case (fin_side.sector)
            SECTOR_RED:   hue_base = '0;
            SECTOR_GREEN: hue_base = HUE_120;
            SECTOR_BLUE:  hue_base = HUE_240;
            default:      hue_base = '0;
        endcase

        hsv_next.brightness = fin_side.hi;
        if (fin_side.grey)
        begin
            hsv_next.hue        = '0;
            hsv_next.saturation = '0;
        end
        else
        begin
            hsv_next.saturation = dv_sq_reg[DIV_STAGES];
            if (fin_side.sector == SECTOR_RED)
            begin
                // truncated toward zero, then wrapped into one turn
                if (fin_side.neg && (hq_ext != '0))
                begin
                    hsv_next.hue = HUE_FULL - hq_ext;
                end
                else
                begin
                    hsv_next.hue = hq_ext;
                end
            end
            else if (fin_side.neg)
            begin
                // numerator stays positive here, so the quotient rounds down
                hsv_next.hue = hue_base - hq_ext - HUE_BITS'(rem_nz);
            end
            else
            begin
                hsv_next.hue = hue_base + hq_ext;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        hsv_reg <= hsv_next;
    end

    assign done = done_reg;
    assign hsv  = hsv_reg;

`ifndef SYNTHESIS
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("item accepted but no result after pipeline latency");

    a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##LATENCY !done)
        else $error("result without a matching accepted item");

    a_black : assert property (@(posedge clk) disable iff (!rst_n)
        (done && (hsv.brightness == '0)) |-> ((hsv.hue == '0) && (hsv.saturation == '0)))
        else $error("black pixel with nonzero hue or saturation");

    a_hue_range : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hsv.hue < HUE_FULL))
        else $error("hue outside one full turn");
`endif

endmodule

[dv/rgb_to_hsv_converter_tb.sv]
// testbench for the rgb to hsv converter: directed table, random pixels, scoreboard check
module rgb_to_hsv_converter_tb;

    import rhsv_pkg::*;

    localparam int HUE_SCALE   = 1 << HUE_FRACTION_BITS;
    localparam int CHAN_FULL   = (1 << CHANNEL_BITS) - 1;
    localparam int PIXEL_BITS  = $bits(pixel_t);
    localparam int RAND_ITEMS  = 250;
    localparam int SETTLE      = 2 * (DIV_STAGES + 3);
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        pixel_t px;
        bit     known;
        hsv_t   want;
    } pixel_row_t;

    logic   clk;
    logic   rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    pixel_t pixel = '0;
    logic   done;
    hsv_t   hsv;

    hsv_t   hsv_queue[$];
    hsv_t   head_hsv;
    int     errors   = 0;
    int     items    = 0;
    int     greys    = 0;
    int     checked  = 0;
    int     cycles   = 0;

    // hue that is read off at a glance is typed in, the rest comes from the predictor
    pixel_row_t dir_rows [20] = '{
        '{'{8'd0,   8'd0,   8'd0},   1'b1, '{15'd0,    8'd0,   8'd0}},
        '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{15'd0,    8'd0,   8'd255}},
        '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{15'd0,    8'd0,   8'd128}},
        '{'{8'd1,   8'd1,   8'd1},   1'b1, '{15'd0,    8'd0,   8'd1}},
        '{'{8'd255, 8'd0,   8'd0},   1'b1, '{15'd0,    8'd255, 8'd255}},
        '{'{8'd0,   8'd255, 8'd0},   1'b1, '{HUE_120,  8'd255, 8'd255}},
        '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{HUE_240,  8'd255, 8'd255}},
        '{'{8'd255, 8'd255, 8'd0},   1'b1, '{15'd3840, 8'd255, 8'd255}},
        '{'{8'd0,   8'd255, 8'd255}, 1'b0, '0},
        '{'{8'd255, 8'd0,   8'd255}, 1'b0, '0},
        '{'{8'd255, 8'd0,   8'd1},   1'b0, '0},
        '{'{8'd1,   8'd0,   8'd0},   1'b0, '0},
        '{'{8'd0,   8'd1,   8'd255}, 1'b0, '0},
        '{'{8'd254, 8'd255, 8'd255}, 1'b0, '0},
        '{'{8'd170, 8'd85,  8'd255}, 1'b0, '0},
        '{'{8'd0,   8'd128, 8'd128}, 1'b0, '0},
        '{'{8'd255, 8'd128, 8'd128}, 1'b0, '0},
        '{'{8'd3,   8'd2,   8'd1},   1'b0, '0},
        '{'{8'hAA,  8'h55,  8'h00},  1'b0, '0},
        '{'{8'h55,  8'hAA,  8'hFF},  1'b0, '0}
    };

    rgb_to_hsv_converter i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .pixel (pixel),
        .done  (done),
        .hsv   (hsv)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic hsv_t hsv_of(input pixel_t p);
        int      r;
        int      g;
        int      b;
        int      hi;
        int      lo;
        int      delta;
        int      offset;
        int      diff;
        int      h;
        sector_t sector;
        hsv_t    res;
        r = p.red;
        g = p.green;
        b = p.blue;
        hi = (r > g) ? r : g;
        lo = (r < g) ? r : g;
        if (b > hi)
            hi = b;
        if (b < lo)
            lo = b;
        delta = hi - lo;
        res = '0;
        res.brightness = hi[CHANNEL_BITS-1:0];
        if (delta != 0)
        begin
            res.saturation = CHANNEL_BITS'((delta * CHAN_FULL) / hi);
            // ties go to red first, then green
            if (r == hi)
                sector = SECTOR_RED;
            else if (g == hi)
                sector = SECTOR_GREEN;
            else
                sector = SECTOR_BLUE;
            case (sector)
                SECTOR_RED:
                begin
                    offset = 0;
                    diff = g - b;
                end
                SECTOR_GREEN:
                begin
                    offset = 120;
                    diff = b - r;
                end
                default:
                begin
                    offset = 240;
                    diff = r - g;
                end
            endcase
            // signed int division truncates toward zero
            h = ((offset * delta + 60 * diff) * HUE_SCALE) / delta;
            if (h < 0)
                h += 360 * HUE_SCALE;
            res.hue = HUE_BITS'(h);
        end
        return res;
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t                  p;
        int                      v;
        int                      w;
        logic [CHANNEL_BITS-1:0] cv;
        logic [CHANNEL_BITS-1:0] cw;
        p = pixel_t'(PIXEL_BITS'($urandom));
        v = $urandom_range(0, CHAN_FULL);
        w = $urandom_range(0, v);
        cv = CHANNEL_BITS'(v);
        cw = CHANNEL_BITS'(w);
        case ($urandom_range(0, 6))
            0, 1: ;
            2: p = '{cv, cv, cv};
            // two channels share the maximum
            3: p = '{cv, cv, cw};
            4: p = '{cw, cv, cv};
            5: p = '{cv, cw, cv};
            default:
            begin
                // pinned at range ends (blue at times random), or close to each other
                if ($urandom_range(0, 1))
                begin
                    p.red   = ($urandom_range(0, 1) != 0) ? '1 : '0;
                    p.green = ($urandom_range(0, 1) != 0) ? '1 : '0;
                    p.blue  = ($urandom_range(0, 2) == 0) ? p.blue : '1;
                end
                else
                begin
                    w = (v > CHAN_FULL - 3) ? CHAN_FULL - 3 : v;
                    p = '{CHANNEL_BITS'(w + int'($urandom_range(0, 3))),
                          CHANNEL_BITS'(w + int'($urandom_range(0, 3))),
                          CHANNEL_BITS'(w + int'($urandom_range(0, 3)))};
                end
            end
        endcase
        return p;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        errors++;
    endtask

    task automatic send_pixel(input pixel_t p, input bit known, input hsv_t want,
                              input int idle_pct);
        // each cycle the sender stays idle with the given chance
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            pixel <= pixel_t'(PIXEL_BITS'($urandom));
            @(posedge clk);
        end
        start <= 1'b1;
        pixel <= p;
        do
            @(posedge clk);
        while (busy);
        hsv_queue.push_back(known ? want : hsv_of(p));
        items++;
        if (p.red == p.green && p.green == p.blue)
            greys++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (hsv_queue.size() != 0)
            @(posedge clk);
    endtask

    // results cannot be held off, so every done cycle is checked
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (hsv_queue.size() == 0)
                report_mismatch("unexpected item, hue", int'(hsv.hue), 0);
            else
            begin
                head_hsv = hsv_queue.pop_front();
                checked++;
                if (hsv.hue !== head_hsv.hue)
                    report_mismatch("hue", int'(hsv.hue), int'(head_hsv.hue));
                if (hsv.saturation !== head_hsv.saturation)
                    report_mismatch("saturation", int'(hsv.saturation),
                                    int'(head_hsv.saturation));
                if (hsv.brightness !== head_hsv.brightness)
                    report_mismatch("brightness", int'(hsv.brightness),
                                    int'(head_hsv.brightness));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d items outstanding", cycles,
                     hsv_queue.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_pixel(dir_rows[i].px, dir_rows[i].known, dir_rows[i].want, 36);
        // sender holds off until the pipeline is empty
        drain();

        for (int i = 0; i < RAND_ITEMS; i++)
            send_pixel(random_pixel(), 1'b0, '0, 36);
        drain();
        for (int i = 0; i < RAND_ITEMS; i++)
            send_pixel(random_pixel(), 1'b0, '0, 55);
        for (int i = 0; i < RAND_ITEMS; i++)
            send_pixel(random_pixel(), 1'b0, '0, 0);

        drain();
        repeat (SETTLE) @(posedge clk);

        $display("sent %0d pixels (%0d grey) in three idle phases, checked %0d results",
                 items, greys, checked);
        $display("mismatches: %0d", errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
